// ===== src/fdss_pkg.sv =====
`default_nettype none
package fdss_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_PUSH  = 3'd1,
    OP_OPEN  = 3'd2,
    OP_CLOSE = 3'd3,
    OP_SORT  = 3'd4,
    OP_NOP   = 3'd5
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] handle;
    logic [31:0] key;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_LIST_FULL  = 2'd1;
  localparam logic [1:0] ST_STACK_FULL = 2'd2;
  localparam logic [1:0] ST_NO_FRAME   = 2'd3;

endpackage
`default_nettype wire

// ===== src/fdss_front.sv =====
`default_nettype none
module fdss_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [55:0]     in_tdata,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready,
  output fdss_pkg::cmd_t       cmd
);

  fdss_pkg::cmd_t q_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  fdss_pkg::cmd_t dec;
  logic           push, pop;

  // unused opcodes become no-ops here
  always_comb begin
    dec.op     = (in_tdata[2:0] <= 3'(fdss_pkg::OP_SORT)) ?
                 fdss_pkg::op_t'(in_tdata[2:0]) : fdss_pkg::OP_NOP;
    dec.handle = in_tdata[18:3];
    dec.key    = in_tdata[50:19];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== src/fdss_back.sv =====
`default_nettype none
module fdss_back #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_FRAMES  = 16,
  parameter int KEY_BITS    = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           tie_reverse,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire fdss_pkg::cmd_t cmd,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [55:0]         out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int FD_W  = $clog2(MAX_FRAMES + 1);
  localparam int FI_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SK_W  = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int ME_W  = 16 + SK_W;

  fdss_pkg::state_t state_r, state_nxt;

  logic [ME_W-1:0]  mem [MAX_ENTRIES];
  logic [ME_W-1:0]  mem_q;
  logic [CNT_W-1:0] cnt_r;
  logic [FD_W-1:0]  depth_r;
  logic [CNT_W-1:0] marks_r [MAX_FRAMES];

  logic [1:0]       res_kind_r, res_status_r;
  logic [IDX_W-1:0] first_r, scan_r, cmp_idx_r;
  logic [CNT_W-1:0] n_r, emit_r;
  logic             cmp_vld_r;
  logic [15:0]      best_handle_r;
  logic [SK_W-1:0]  best_key_r, prev_key_r;
  logic [IDX_W-1:0] best_idx_r, prev_idx_r;
  logic             best_vld_r, prev_vld_r;

  logic             out_vld_r, out_last_r;
  logic [15:0]      out_handle_r;
  logic [31:0]      out_key_r;
  logic [1:0]       out_kind_r, out_status_r;

  logic [CNT_W-1:0] top_mark, first_raw, first_c, n_c;
  logic [IDX_W-1:0] end_idx;
  logic [SK_W-1:0]  key_c;
  logic             eligible, better, emit_last, out_free, out_ld, take;

  assign top_mark  = marks_r[FI_W'(depth_r - 1'b1)];
  assign first_raw = (depth_r != '0) ? top_mark : '0;
  assign first_c   = (first_raw > cnt_r) ? cnt_r : first_raw;
  assign n_c       = cnt_r - first_c;
  assign end_idx   = IDX_W'(cnt_r - 1'b1);
  assign key_c     = mem_q[SK_W-1:0];
  assign emit_last = (CNT_W'(emit_r + 1'b1) == n_r);

  // strictly after the previous pick in (key desc, tie order by index) order
  assign eligible = !prev_vld_r || (key_c < prev_key_r) ||
                    ((key_c == prev_key_r) &&
                     (tie_reverse ? (cmp_idx_r < prev_idx_r) : (cmp_idx_r > prev_idx_r)));
  assign better   = !best_vld_r || (key_c > best_key_r) ||
                    ((key_c == best_key_r) &&
                     (tie_reverse ? (cmp_idx_r > best_idx_r) : (cmp_idx_r < best_idx_r)));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fdss_pkg::S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.op == fdss_pkg::OP_SORT && n_c != '0) ?
                      fdss_pkg::S_SCAN : fdss_pkg::S_EXEC;
        end
      end
      fdss_pkg::S_EXEC:  if (out_free) state_nxt = fdss_pkg::S_IDLE;
      fdss_pkg::S_SCAN:  if (scan_r == end_idx) state_nxt = fdss_pkg::S_DRAIN;
      fdss_pkg::S_DRAIN: state_nxt = fdss_pkg::S_EMIT;
      fdss_pkg::S_EMIT: begin
        if (out_free) state_nxt = emit_last ? fdss_pkg::S_IDLE : fdss_pkg::S_SCAN;
      end
      default: state_nxt = fdss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_free  = !out_vld_r || out_tready;
    cmd_ready = (state_r == fdss_pkg::S_IDLE);
    take      = cmd_ready && cmd_valid;
    out_ld    = out_free &&
                (state_r == fdss_pkg::S_EXEC || state_r == fdss_pkg::S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (take && cmd.op == fdss_pkg::OP_PUSH && cnt_r < CNT_W'(MAX_ENTRIES)) begin
      mem[cnt_r[IDX_W-1:0]] <= {cmd.handle, cmd.key[SK_W-1:0]};
    end
    if (state_r == fdss_pkg::S_SCAN) begin
      mem_q <= mem[scan_r];
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.op == fdss_pkg::OP_OPEN && depth_r < FD_W'(MAX_FRAMES)) begin
      marks_r[depth_r[FI_W-1:0]] <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fdss_pkg::S_IDLE;
      cnt_r     <= '0;
      depth_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == fdss_pkg::S_SCAN);
      if (out_ld) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
      if (take) begin
        unique case (cmd.op)
          fdss_pkg::OP_CLEAR: begin
            cnt_r   <= '0;
            depth_r <= '0;
          end
          fdss_pkg::OP_PUSH: if (cnt_r < CNT_W'(MAX_ENTRIES)) cnt_r <= cnt_r + 1'b1;
          fdss_pkg::OP_OPEN: if (depth_r < FD_W'(MAX_FRAMES)) depth_r <= depth_r + 1'b1;
          fdss_pkg::OP_CLOSE: begin
            if (depth_r != '0) begin
              depth_r <= depth_r - 1'b1;
              if (top_mark < cnt_r) cnt_r <= top_mark;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_kind_r   <= (cmd.op == fdss_pkg::OP_SORT) ? fdss_pkg::KIND_EMPTY
                                                    : fdss_pkg::KIND_ACK;
      if (cmd.op == fdss_pkg::OP_PUSH && cnt_r >= CNT_W'(MAX_ENTRIES))
        res_status_r <= fdss_pkg::ST_LIST_FULL;
      else if (cmd.op == fdss_pkg::OP_OPEN && depth_r >= FD_W'(MAX_FRAMES))
        res_status_r <= fdss_pkg::ST_STACK_FULL;
      else if (cmd.op == fdss_pkg::OP_CLOSE && depth_r == '0)
        res_status_r <= fdss_pkg::ST_NO_FRAME;
      else
        res_status_r <= fdss_pkg::ST_OK;
      first_r    <= IDX_W'(first_c);
      scan_r     <= IDX_W'(first_c);
      n_r        <= n_c;
      emit_r     <= '0;
      best_vld_r <= 1'b0;
      prev_vld_r <= 1'b0;
    end
    if (state_r == fdss_pkg::S_SCAN) begin
      cmp_idx_r <= scan_r;
      if (scan_r != end_idx) scan_r <= scan_r + 1'b1;
    end
    if (cmp_vld_r && eligible && better) begin
      best_vld_r    <= 1'b1;
      best_handle_r <= mem_q[ME_W-1:SK_W];
      best_key_r    <= key_c;
      best_idx_r    <= cmp_idx_r;
    end
    if (out_ld && state_r == fdss_pkg::S_EMIT) begin
      prev_vld_r <= 1'b1;
      prev_key_r <= best_key_r;
      prev_idx_r <= best_idx_r;
      best_vld_r <= 1'b0;
      emit_r     <= emit_r + 1'b1;
      scan_r     <= first_r;
    end
    if (out_ld) begin
      if (state_r == fdss_pkg::S_EMIT) begin
        out_handle_r <= best_handle_r;
        out_key_r    <= 32'(best_key_r);
        out_kind_r   <= fdss_pkg::KIND_ENTRY;
        out_status_r <= fdss_pkg::ST_OK;
        out_last_r   <= emit_last;
      end else begin
        out_handle_r <= '0;
        out_key_r    <= '0;
        out_kind_r   <= res_kind_r;
        out_status_r <= res_status_r;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_status_r, out_key_r, out_handle_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== src/framed_stable_depth_sorter.sv =====
// Depth sorter for a framed entry list. Each input request is one operation
// (clear, push, open frame, close frame, sort); a two-deep command queue lets
// the input side run ahead of execution. Clear, push, open, close and unused
// opcodes give one acknowledgement each. A sort of n entries in the current
// frame emits n results, farthest key first, stable on ties unless tie_reverse
// is set; each result comes from one full pass over the frame through the
// single registered read port of the entry memory, and input is held off
// (once the queue fills) until the sort ends.
// The tie order register may be written only while the block is idle.
`default_nettype none
module framed_stable_depth_sorter #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_FRAMES  = 16,
  parameter int KEY_BITS    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // opcode[2:0], sprite_handle[18:3], distance_key[50:19]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // out_handle[15:0], out_key[47:16], status[49:48]
  output logic [1:0]       out_tuser,  // kind[1:0]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data    // tie_reverse
);

  logic           tie_reverse_r;
  logic           cmd_valid, cmd_ready;
  fdss_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tie_reverse_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      tie_reverse_r <= cfg_data;
    end
  end

  fdss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  fdss_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_FRAMES  (MAX_FRAMES),
    .KEY_BITS    (KEY_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tie_reverse (tie_reverse_r),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // queue only fills by taking a request
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("input queue filled without a request");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == fdss_pkg::KIND_EMPTY |-> out_tlast)
    else $error("empty sort result not marked last");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != fdss_pkg::KIND_ACK |-> out_tdata[49:48] == fdss_pkg::ST_OK)
    else $error("status set on a sort result");

  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == fdss_pkg::KIND_ACK |-> out_tdata[47:0] == '0 && out_tlast)
    else $error("acknowledgement carries data");

endmodule
`default_nettype wire
